// File: design/vtdi_pkg.sv
// Package for the vertex triple dedup indexer.
// Holds the corner and vertex beat structs and the query token control struct.
// No dependencies.
`timescale 1ns / 1ps

package vtdi_pkg;

    typedef struct packed {
        logic        first_of_mesh;
        logic [15:0] position_index;
        logic [15:0] texcoord_index;
        logic [15:0] normal_index;
    } t_corner;

    typedef struct packed {
        logic [7:0] vertex_slot;
        logic       is_new_vertex;
        logic       table_overflow;
    } t_vertex;

    // Control part of the query token that walks the cell row.
    typedef struct packed {
        logic valid;
        logic found;
        logic is_new;
    } t_tok_ctrl;

endpackage

// File: design/vtdi_cell.sv
// One table cell of the vertex triple dedup indexer.
// Holds one stored triple, checks the passing query token and forwards it.
// Depends on vtdi_pkg.
`timescale 1ns / 1ps

module vtdi_cell #(
    parameter int CELL_IDX = 0,
    parameter int KEY_W    = 48,
    parameter int SLOT_W   = 8,
    parameter int USED_W   = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [USED_W-1:0]    i_used,
    input  vtdi_pkg::t_tok_ctrl  i_ctrl,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [SLOT_W-1:0]    i_slot,
    output vtdi_pkg::t_tok_ctrl  o_ctrl,
    output logic [KEY_W-1:0]     o_key,
    output logic [SLOT_W-1:0]    o_slot
);
    import vtdi_pkg::*;

    localparam logic [USED_W-1:0] MyPos  = USED_W'(CELL_IDX);
    localparam logic [SLOT_W-1:0] MySlot = SLOT_W'(CELL_IDX);

    logic [KEY_W-1:0]  r_entry;
    t_tok_ctrl         r_ctrl;
    t_tok_ctrl         n_ctrl;
    logic [KEY_W-1:0]  r_key;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              hit;
    logic              append;

    // A cell below the fill count is a live entry; the cell at the fill count
    // is the next free position.
    assign hit    = i_ctrl.valid && !i_ctrl.found && (MyPos < i_used) && (r_entry == i_key);
    assign append = i_ctrl.valid && !i_ctrl.found && (MyPos == i_used);

    always_comb begin
        n_ctrl = i_ctrl;
        n_slot = i_slot;
        if (hit || append) begin
            n_ctrl.found = 1'b1;
            n_slot       = MySlot;
        end
        if (append) begin
            n_ctrl.is_new = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_slot <= n_slot;
        if (append) begin
            r_entry <= i_key;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_key  = r_key;
    assign o_slot = r_slot;

endmodule

// File: design/vertex_triple_dedup_indexer_unit.sv
// Top level of the vertex triple dedup indexer.
// Builds the row of table cells and the command and result ports.
// Depends on vtdi_pkg and vtdi_cell.
`timescale 1ns / 1ps

// Usage.
// Each input beat is one face corner on i_corner: a position, texture
// coordinate and normal index triple plus a first-of-mesh flag. A beat is
// taken at a rising edge where start is high and busy is low. The block then
// raises busy and works on that corner alone.
// The triple travels as a query token down a row of TABLE_DEPTH cells, one
// cell per cycle. Each cell holds one stored triple. The first live cell that
// matches claims the token; if none does, the cell at the fill count stores
// the triple and marks it new. If the table is full, the token leaves the
// row unclaimed and the result reports overflow.
// The result beat appears on o_vertex with o_valid high for exactly one cycle,
// once the token has passed the launch register and every cell register, and
// is taken at the edge that ends it. busy drops at the end of that cycle, so
// a new corner can be taken in the cycle after; the walk of the token along
// the cell row sets the pace, with one corner in flight at a time.
// The receiver cannot stall; it must take each result in its strobe cycle.
// Reset clears the fill count, busy and the token valid bits. Stored triples
// are not cleared; the fill count alone decides which cells are live.
// A first-of-mesh corner empties the table before its own lookup.

module vertex_triple_dedup_indexer_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int INDEX_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vtdi_pkg::t_corner i_corner,
    output logic              o_valid,
    output vtdi_pkg::t_vertex o_vertex
);
    import vtdi_pkg::*;

    localparam int KEY_W  = 3 * INDEX_BITS;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    logic               r_busy;
    logic [USED_W-1:0]  r_used;
    t_tok_ctrl          r_ctrl;
    logic [KEY_W-1:0]   r_key;
    logic               accept;

    t_tok_ctrl          ctrl_chain [TABLE_DEPTH+1];
    logic [KEY_W-1:0]   key_chain  [TABLE_DEPTH+1];
    logic [SLOT_W-1:0]  slot_chain [TABLE_DEPTH+1];
    t_tok_ctrl          tail_ctrl;

    // The last key copy is not needed past the row.
    logic               unused_key;

    assign accept = start && !r_busy;

    // Busy covers the whole walk; it falls at the end of the result cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (tail_ctrl.valid) begin
            r_busy <= 1'b0;
        end
    end

    // The fill count is cleared at the accepting edge of a mesh start, so the
    // cells see the emptied table for the whole walk of that corner.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (accept && i_corner.first_of_mesh) begin
            r_used <= '0;
        end else if (tail_ctrl.valid && tail_ctrl.is_new) begin
            r_used <= r_used + 1'b1;
        end
    end

    // Launch register: holds the token in front of cell zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl.valid  <= accept;
            r_ctrl.found  <= 1'b0;
            r_ctrl.is_new <= 1'b0;
        end
    end

    // Each index is cut to its low INDEX_BITS bits, or widened with zeros.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= {INDEX_BITS'(i_corner.position_index),
                      INDEX_BITS'(i_corner.texcoord_index),
                      INDEX_BITS'(i_corner.normal_index)};
        end
    end

    assign ctrl_chain[0] = r_ctrl;
    assign key_chain[0]  = r_key;
    assign slot_chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vtdi_cell #(
            .CELL_IDX (g),
            .KEY_W    (KEY_W),
            .SLOT_W   (SLOT_W),
            .USED_W   (USED_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_used  (r_used),
            .i_ctrl  (ctrl_chain[g]),
            .i_key   (key_chain[g]),
            .i_slot  (slot_chain[g]),
            .o_ctrl  (ctrl_chain[g+1]),
            .o_key   (key_chain[g+1]),
            .o_slot  (slot_chain[g+1])
        );
    end

    assign tail_ctrl = ctrl_chain[TABLE_DEPTH];

    // A token that leaves the row unclaimed met a full table.
    always_comb begin
        o_vertex.vertex_slot    = tail_ctrl.found ? 8'(slot_chain[TABLE_DEPTH]) : 8'd0;
        o_vertex.is_new_vertex  = tail_ctrl.is_new;
        o_vertex.table_overflow = !tail_ctrl.found;
    end

    assign o_valid = tail_ctrl.valid;
    assign busy    = r_busy;

    assign unused_key = ^key_chain[TABLE_DEPTH];

endmodule

// File: design/vtdi_checker.sv
// Port-level checker for the vertex triple dedup indexer, with its bind.
// Watches the command and result ports of vertex_triple_dedup_indexer_unit.
// Depends on vtdi_pkg.
`timescale 1ns / 1ps

module vtdi_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input vtdi_pkg::t_vertex o_vertex
);
    import vtdi_pkg::*;

    // A result beat only comes while a corner is in flight.
    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy period");

    // The block is free again right after its result beat.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy still high after the result beat");

    // An accepted corner makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted corner");

    // A new vertex and an overflow exclude each other.
    a_new_or_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_vertex.is_new_vertex && o_vertex.table_overflow))
        else $error("new vertex and overflow in one beat");

    // An overflow reports slot zero.
    a_overflow_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vertex.table_overflow) |-> (o_vertex.vertex_slot == 8'd0))
        else $error("overflow beat with a nonzero slot");

endmodule

bind vertex_triple_dedup_indexer_unit vtdi_checker u_vtdi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_vertex (o_vertex)
);

// File: verif/vertex_triple_dedup_indexer_unit_tb.sv
// Self-checking testbench for the vertex triple dedup indexer unit.
// Drives face corner beats, predicts each vertex beat with a local table model and
// checks it field by field. Depends on vtdi_pkg and vertex_triple_dedup_indexer_unit.
`timescale 1ns / 1ps

module vertex_triple_dedup_indexer_unit_tb;

    import vtdi_pkg::*;

    // The block is built with its default sizes. The predictor uses the same
    // numbers, so narrow index widths would be cut the same way on both sides.
    localparam int TB_DEPTH    = 256;
    localparam int TB_IDX_BITS = 16;
    localparam logic [15:0] IDX_MASK = 16'((64'd1 << TB_IDX_BITS) - 1);

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    start    = 1'b0;
    t_corner i_corner = '0;
    logic    busy;
    logic    o_valid;
    t_vertex o_vertex;

    vertex_triple_dedup_indexer_unit #(
        .TABLE_DEPTH(TB_DEPTH),
        .INDEX_BITS (TB_IDX_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_corner(i_corner),
        .o_valid (o_valid),
        .o_vertex(o_vertex)
    );

    // Free-running 4 ns clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor state: the distinct triples in order of first appearance and
    // the number of live entries. Entries at or above the fill count are stale
    // and never take part in a lookup.
    logic [47:0] stored_triples [TB_DEPTH];
    int unsigned fill_count = 0;

    // Vertex beats predicted for accepted corners, oldest first.
    t_vertex pending_vertices [$];
    int      error_count = 0;

    // When set, the sender offers every corner without random gaps.
    bit      no_idle = 1'b0;

    // Looks one corner up in the predicted table and updates the table the same
    // way the block does: a mesh start empties it first, the lowest matching
    // entry answers, a miss appends, and a miss on a full table overflows.
    function automatic t_vertex lookup_corner(input t_corner c);
        logic [47:0] key;
        t_vertex     v;
        bit          hit;
        key = {c.position_index & IDX_MASK, c.texcoord_index & IDX_MASK,
               c.normal_index & IDX_MASK};
        v   = '0;
        hit = 1'b0;
        if (c.first_of_mesh) begin
            fill_count = 0;
        end
        for (int i = 0; i < int'(fill_count); i++) begin
            if (!hit && stored_triples[i] == key) begin
                hit = 1'b1;
                v.vertex_slot = 8'(i);
            end
        end
        if (!hit) begin
            if (fill_count < TB_DEPTH) begin
                stored_triples[fill_count] = key;
                v.vertex_slot   = 8'(fill_count);
                v.is_new_vertex = 1'b1;
                fill_count++;
            end else begin
                v.table_overflow = 1'b1;
            end
        end
        return v;
    endfunction

    // Offers one corner beat until the block takes it. In a cycle where the
    // sender idles, start is low and the corner bus carries junk. The beat is
    // taken at an edge where start is high and busy is low; busy is read right
    // after the edge, so it still holds the value the block saw at that edge.
    // On return start is left high, so the next call can keep offering without
    // a second assignment in the same step.
    task automatic issue_corner(input t_corner c);
        logic [63:0] junk;
        bit          offer;
        bit          taken;
        taken = 1'b0;
        while (!taken) begin
            offer = no_idle || ($urandom_range(99) >= 8);
            junk  = {$urandom(), $urandom()};
            start    <= offer;
            i_corner <= offer ? c : t_corner'(junk[48:0]);
            @(posedge i_clk);
            if (offer && !busy) begin
                taken = 1'b1;
            end
        end
        pending_vertices = {pending_vertices, lookup_corner(c)};
    endtask

    // Builds a corner from its flag and its three indices.
    function automatic t_corner corner_of(input logic first, input logic [15:0] pos,
                                          input logic [15:0] tex, input logic [15:0] nrm);
        t_corner c;
        c.first_of_mesh  = first;
        c.position_index = pos;
        c.texcoord_index = tex;
        c.normal_index   = nrm;
        return c;
    endfunction

    // Every vertex beat is taken in its strobe cycle and matched against the
    // oldest prediction. The outputs are read right after the edge, which gives
    // the values that were valid during the cycle the edge ends.
    always @(posedge i_clk) begin : check_vertex
        t_vertex want;
        if (i_rst_n && o_valid) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex beat with no corner pending: slot %0d new %0b overflow %0b",
                       o_vertex.vertex_slot, o_vertex.is_new_vertex,
                       o_vertex.table_overflow);
                error_count++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_vertex.vertex_slot !== want.vertex_slot) begin
                    $error("vertex_slot: expected %0d, got %0d",
                           want.vertex_slot, o_vertex.vertex_slot);
                    error_count++;
                end
                if (o_vertex.is_new_vertex !== want.is_new_vertex) begin
                    $error("is_new_vertex: expected %0b, got %0b",
                           want.is_new_vertex, o_vertex.is_new_vertex);
                    error_count++;
                end
                if (o_vertex.table_overflow !== want.table_overflow) begin
                    $error("table_overflow: expected %0b, got %0b",
                           want.table_overflow, o_vertex.table_overflow);
                    error_count++;
                end
            end
        end
    end

    // Corners straight after reset, without a mesh start: the table must come
    // up empty. Covers the all-zero and all-one indices, each field alone at its
    // maximum, a triple that differs from another only in one low bit, and hits
    // on entries appended earlier.
    task automatic test_field_extremes();
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_corner(corner_of(1'b0, 16'hFFFF, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b0, 16'h0000, 16'hFFFF, 16'h0000));
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'hFFFF));
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'h0001));
        issue_corner(corner_of(1'b0, 16'h0000, 16'hFFFF, 16'h0000));
    endtask

    // A mesh start empties the table: a triple that would have hit comes back
    // as a new entry at slot 0, and the following corners refill from there.
    task automatic test_mesh_restart();
        issue_corner(corner_of(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_corner(corner_of(1'b1, 16'h0000, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b0, 16'h0000, 16'h0000, 16'h0000));
        issue_corner(corner_of(1'b1, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Fills all entries with distinct triples, then checks that a new triple
    // overflows while stored ones, the first and the last, still hit. A mesh
    // start on a full table must land its corner at slot 0 as a new entry.
    task automatic test_table_full();
        for (int k = 0; k < TB_DEPTH; k++) begin
            issue_corner(corner_of(k == 0, 16'(k), 16'(~k), 16'(k * 3)));
        end
        issue_corner(corner_of(1'b0, 16'h1234, 16'h5678, 16'h9ABC));
        issue_corner(corner_of(1'b0, 16'(0), 16'(~0), 16'(0)));
        issue_corner(corner_of(1'b0, 16'(TB_DEPTH - 1), 16'(~(TB_DEPTH - 1)),
                               16'((TB_DEPTH - 1) * 3)));
        issue_corner(corner_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_corner(corner_of(1'b1, 16'(5), 16'(~5), 16'(15)));
        issue_corner(corner_of(1'b0, 16'(TB_DEPTH - 1), 16'(~(TB_DEPTH - 1)),
                               16'((TB_DEPTH - 1) * 3)));
    endtask

    // Random meshes. Each mesh opens with a mesh start and then repeats
    // triples drawn from its own pool, so hits and appends mix. About one mesh
    // in eight is long and mostly new, which runs the table into overflow and
    // keeps hitting after it. Indices are either full-range or small, the small
    // ones giving near misses that differ in one field only. A rare stray mesh
    // start in the middle of a mesh acts as noise. The first few hundred corners
    // go out with no sender gaps at all.
    task automatic test_random_meshes(input int n_items);
        logic [47:0] mesh_pool [$];
        logic [47:0] trip;
        int          mesh_len;
        int          hit_pct;
        int          sent;
        t_corner     c;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) begin
                mesh_len = $urandom_range(290, 340);
                hit_pct  = 10;
            end else begin
                mesh_len = $urandom_range(4, 80);
                hit_pct  = 45;
            end
            mesh_pool.delete();
            for (int k = 0; k < mesh_len && sent < n_items; k++) begin
                no_idle = (sent < 300);
                if (k > 0 && $urandom_range(99) < hit_pct) begin
                    trip = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
                end else begin
                    if ($urandom_range(1) == 0) begin
                        trip = {16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                16'($urandom_range(65535))};
                    end else begin
                        trip = {16'($urandom_range(7)), 16'($urandom_range(7)),
                                16'($urandom_range(7))};
                    end
                    mesh_pool = {mesh_pool, trip};
                end
                c.first_of_mesh = (k == 0) || ($urandom_range(99) < 2);
                {c.position_index, c.texcoord_index, c.normal_index} = trip;
                issue_corner(c);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // Main sequence: one reset, the directed tests, the random meshes, then a
    // drain. start is lowered right after the last beat is taken, while the
    // block is busy, so nothing further is accepted.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_mesh_restart();
        test_table_full();
        test_random_meshes(1120);
        start <= 1'b0;
        while (pending_vertices.size() != 0) begin
            @(posedge i_clk);
        end
        // One more lookup walk, to catch any stray beat behind the last one.
        repeat (TB_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog. About 1400 corners need under 2 ms;
    // this allows several times that.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
